// ===== rtl/pcrps_pkg.sv =====
`timescale 1ns / 1ps

package pcrps_pkg;

	// screen geometry
	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 480;

	// projection constants, all in mm or pixels
	localparam int CAM_DIST_MM  = 4200;
	localparam int NEAR_MM      = 500;
	localparam int FOCAL        = 620;
	localparam int Y_LIFT_MM    = 100;
	localparam int Y_OFFSET_PX  = 30;
	localparam int CENTER_X     = SCREEN_WIDTH / 2;
	localparam int CENTER_Y     = SCREEN_HEIGHT / 2 + Y_OFFSET_PX;

	// depth shade in q1.8: floor(n * 256 / 2600) as (n * ceil(2^32 / 2600)) >> 24
	localparam int SHADE_TOP_MM   = 5800;
	localparam int SHADE_CLAMP_MM = 2700;
	localparam int SHADE_RECIP    = 1651911;
	localparam int SHADE_MIN_Q8   = 90;
	localparam int SHADE_MAX_Q8   = 256;

	// body colour channel weights
	localparam int RED_K   = 255;
	localparam int GREEN_K = 150;
	localparam int BLUE_K  = 60;

	// work queue between front and back
	localparam int QDEPTH   = 8;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int CREDIT_W = QPTR_W + 1;

	// divider: 28 dividend bits, 7 quotient bits per pass
	localparam int DIV_W      = 28;
	localparam int DIV_BITS   = 7;
	localparam int DIV_PASSES = DIV_W / DIV_BITS;
	localparam int CZ_W       = 18;
	localparam int QUO_W      = 19;

	// configuration register indexes
	localparam logic CFG_COS = 1'b0;
	localparam logic CFG_SIN = 1'b1;

	// one projected vertex waiting for its divisions
	typedef struct packed {
		logic signed [DIV_W-1:0] num_x;
		logic signed [DIV_W-1:0] num_y;
		logic [CZ_W-1:0]         cz;
		logic [23:0]             bgr;
	} work_t;

endpackage

// ===== rtl/point_cloud_rotate_project_splat.sv =====
`timescale 1ns / 1ps

// vertex rotate, project and 2x2 splat. a vertex (x_mm, y_mm, z_mm) is taken on any
// edge where start is high and busy is low; busy rises once eight vertices sit
// between accept and the back end, counted over the four-stage front pipe and the
// eight-entry work queue together. each visible vertex gives four
// pixel words, one per cycle with done high, the fourth marked by splat_last; a
// culled or off-screen vertex gives none. the receiver cannot stall, so done words
// must be taken as they come. sustained rate is set by the back end, which loads
// the next vertex as it hands on the last: the two perspective divisions run as
// restoring dividers that retire 7 quotient bits per cycle over 4 passes, and the
// splat emitter writes one pixel per cycle.
// rot_cos / rot_sin are written through the cfg port (index 0 and 1), always ready,
// and must only change while no vertex is in flight.

module point_cloud_rotate_project_splat (
	input  logic               clk,
	input  logic               arst_n,
	// vertex command
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] x_mm,
	input  logic signed [15:0] y_mm,
	input  logic signed [15:0] z_mm,
	// pixel word strobe
	output logic               done,
	output logic [18:0]        pixel_index,
	output logic [31:0]        pixel_colour,
	output logic               splat_last,
	// register writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	// rotation registers, signed q1.14
	logic signed [15:0] cos_q, sin_q;

	// front to queue
	logic             push;
	pcrps_pkg::work_t push_data;

	// queue to back
	logic             head_valid;
	pcrps_pkg::work_t head_data;
	logic             pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= 16'sd16384;
			sin_q <= 16'sd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pcrps_pkg::CFG_COS: cos_q <= cfg_data;
				pcrps_pkg::CFG_SIN: sin_q <= cfg_data;
			endcase
		end
	end

	// front: rotate, near cull, numerators and shade colour; regains a credit per pop and per culled vertex
	pcrps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.x_mm       (x_mm),
		.y_mm       (y_mm),
		.z_mm       (z_mm),
		.rot_cos    (cos_q),
		.rot_sin    (sin_q),
		.credit_ret (pop),
		.push       (push),
		.push_data  (push_data)
	);

	pcrps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// back: divide by depth, clip, emit the four splat words
	pcrps_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_data    (head_data),
		.pop          (pop),
		.done         (done),
		.pixel_index  (pixel_index),
		.pixel_colour (pixel_colour),
		.splat_last   (splat_last)
	);

`ifndef ASSERT_OFF
	// the four words of a splat come in consecutive cycles
	a_splat_burst: assert property (@(posedge clk) disable iff (!arst_n)
		done && !splat_last |=> done)
		else $error("splat burst broken");

	// one colour for the whole splat
	a_splat_colour: assert property (@(posedge clk) disable iff (!arst_n)
		done && !splat_last |=> $stable(pixel_colour))
		else $error("splat colour changed mid burst");
`endif

endmodule

// ===== rtl/pcrps_front.sv =====
`timescale 1ns / 1ps

module pcrps_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [15:0]  x_mm,
	input  logic signed [15:0]  y_mm,
	input  logic signed [15:0]  z_mm,
	input  logic signed [15:0]  rot_cos,
	input  logic signed [15:0]  rot_sin,
	input  logic                credit_ret,
	output logic                push,
	output pcrps_pkg::work_t    push_data
);

	localparam int CW = pcrps_pkg::CREDIT_W;
	localparam int DW = pcrps_pkg::DIV_W;

	logic accept;
	logic [CW-1:0] credit_q;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [15:0] x_s1, y_s1, z_s1;
	logic signed [31:0] xc_s2, zs_s2, xs_s2, zc_s2;
	logic signed [15:0] y_s2;
	logic signed [18:0] rx_s3;
	logic signed [19:0] cz_s3;
	logic signed [16:0] yl_s3;
	logic signed [DW-1:0] numx_s4, numy_s4;
	logic [32:0] shade_s4;
	logic [17:0] cz_s4;
	logic near_s4;

	logic signed [32:0] sum_x, sum_z;
	logic signed [18:0] rz_c;
	logic signed [20:0] n_c;
	logic [11:0] nn_c;
	logic [8:0] q_c, d_c;
	logic [16:0] r_p, g_p, b_p;
	logic drop;

	assign accept = start && !busy;
	assign busy = (credit_q == '0);

	// rotation sums, exact, then arithmetic shift by 14
	assign sum_x = 33'(xc_s2) - 33'(zs_s2);
	assign sum_z = 33'(xs_s2) + 33'(zc_s2);
	assign rz_c = sum_z[32:14];

	// depth shade numerator, clamped so the q1.8 value saturates above 1
	always_comb begin
		n_c = 21'(pcrps_pkg::SHADE_TOP_MM) - 21'(cz_s3);
		if (n_c <= 21'sd0) begin
			nn_c = '0;
		end else if (n_c > 21'(pcrps_pkg::SHADE_CLAMP_MM)) begin
			nn_c = 12'(pcrps_pkg::SHADE_CLAMP_MM);
		end else begin
			nn_c = n_c[11:0];
		end
	end

	always_comb begin
		q_c = shade_s4[32:24];
		if (q_c < 9'(pcrps_pkg::SHADE_MIN_Q8)) begin
			d_c = 9'(pcrps_pkg::SHADE_MIN_Q8);
		end else if (q_c > 9'(pcrps_pkg::SHADE_MAX_Q8)) begin
			d_c = 9'(pcrps_pkg::SHADE_MAX_Q8);
		end else begin
			d_c = q_c;
		end
		r_p = 17'(d_c) * 17'(pcrps_pkg::RED_K);
		g_p = 17'(d_c) * 17'(pcrps_pkg::GREEN_K);
		b_p = 17'(d_c) * 17'(pcrps_pkg::BLUE_K);
	end

	assign push = v_s4 && !near_s4;
	assign drop = v_s4 && near_s4;
	assign push_data.num_x = numx_s4;
	assign push_data.num_y = numy_s4;
	assign push_data.cz    = cz_s4;
	assign push_data.bgr   = {b_p[15:8], g_p[15:8], r_p[15:8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CW'(pcrps_pkg::QDEPTH);
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			credit_q <= credit_q + CW'(credit_ret) + CW'(drop) - CW'(accept);
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= x_mm;
			y_s1 <= y_mm;
			z_s1 <= z_mm;
		end
		xc_s2 <= 32'(x_s1) * 32'(rot_cos);
		zs_s2 <= 32'(z_s1) * 32'(rot_sin);
		xs_s2 <= 32'(x_s1) * 32'(rot_sin);
		zc_s2 <= 32'(z_s1) * 32'(rot_cos);
		y_s2  <= y_s1;
		rx_s3 <= sum_x[32:14];
		cz_s3 <= 20'(rz_c) + 20'(pcrps_pkg::CAM_DIST_MM);
		yl_s3 <= 17'(y_s2) + 17'(pcrps_pkg::Y_LIFT_MM);
		numx_s4  <= DW'(rx_s3) * DW'(pcrps_pkg::FOCAL);
		numy_s4  <= DW'(yl_s3) * DW'(pcrps_pkg::FOCAL);
		shade_s4 <= 33'(nn_c) * 33'(pcrps_pkg::SHADE_RECIP);
		cz_s4    <= cz_s3[17:0];
		near_s4  <= (cz_s3 < 20'(pcrps_pkg::NEAR_MM));
	end

endmodule

// ===== rtl/pcrps_queue.sv =====
`timescale 1ns / 1ps

module pcrps_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pcrps_pkg::work_t push_data,
	input  logic             pop,
	output logic             head_valid,
	output pcrps_pkg::work_t head_data
);

	localparam int PW = pcrps_pkg::QPTR_W;
	localparam int DEPTH = pcrps_pkg::QDEPTH;

	pcrps_pkg::work_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0] cnt_q;

	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q < (PW+1)'(DEPTH))
		else $error("work queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("work queue underflow");
`endif

endmodule

// ===== rtl/pcrps_back.sv =====
`timescale 1ns / 1ps

module pcrps_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  pcrps_pkg::work_t head_data,
	output logic             pop,
	output logic             done,
	output logic [18:0]      pixel_index,
	output logic [31:0]      pixel_colour,
	output logic             splat_last
);

	localparam int DW = pcrps_pkg::DIV_W;
	localparam int ZW = pcrps_pkg::CZ_W;
	localparam int QW = pcrps_pkg::QUO_W;

	// seven restoring steps: shift a dividend bit into the remainder, subtract if it fits
	function automatic logic [ZW+DW-1:0] div_pass(input logic [DW-1:0] dd,
			input logic [ZW-1:0] rem, input logic [ZW-1:0] dv);
		logic [DW-1:0] d;
		logic [ZW:0] r;
		d = dd;
		r = {1'b0, rem};
		for (int i = 0; i < pcrps_pkg::DIV_BITS; i++) begin
			r = {r[ZW-1:0], d[DW-1]};
			d = {d[DW-2:0], 1'b0};
			if (r >= {1'b0, dv}) begin
				r = r - {1'b0, dv};
				d[0] = 1'b1;
			end
		end
		return {r[ZW-1:0], d};
	endfunction

	// divider
	logic dv_busy_q;
	logic [1:0] dv_cnt_q;
	logic [DW-1:0] dx_q, dy_q;
	logic [ZW-1:0] rx_q, ry_q, dz_q;
	logic sx_q, sy_q;
	logic [23:0] dv_bgr_q;
	logic [ZW+DW-1:0] pass_x, pass_y;
	logic dv_last, fin_now, load_div;
	logic [DW-1:0] abs_x, abs_y;

	// finished quotients
	logic fin_valid_q;
	logic signed [QW-1:0] fin_qx_q, fin_qy_q;
	logic [23:0] fin_bgr_q;
	logic signed [QW-1:0] qx_c, qy_c;
	logic fin_free, fin_take;

	// clip
	logic signed [20:0] px_c, py_c;
	logic vis_c;
	logic [31:0] idx_full;

	// splat emitter
	logic em_busy_q;
	logic [1:0] em_k_q;
	logic [18:0] em_base_q;
	logic [23:0] em_bgr_q;
	logic em_load;
	logic [18:0] em_off;

	logic done_q, last_q;
	logic [18:0] idx_q;
	logic [31:0] colour_q;

	assign pass_x = div_pass(dx_q, rx_q, dz_q);
	assign pass_y = div_pass(dy_q, ry_q, dz_q);
	assign dv_last = dv_busy_q && (dv_cnt_q == 2'(pcrps_pkg::DIV_PASSES - 1));
	assign fin_now = dv_last && fin_free;
	assign load_div = head_valid && (!dv_busy_q || fin_now);
	assign pop = load_div;

	assign abs_x = head_data.num_x[DW-1] ? DW'(-head_data.num_x) : DW'(head_data.num_x);
	assign abs_y = head_data.num_y[DW-1] ? DW'(-head_data.num_y) : DW'(head_data.num_y);

	// quotient is below 2^18, so sign and magnitude fit the signed word
	assign qx_c = sx_q ? -QW'(pass_x[DW-1:0]) : QW'(pass_x[DW-1:0]);
	assign qy_c = sy_q ? -QW'(pass_y[DW-1:0]) : QW'(pass_y[DW-1:0]);

	assign px_c = 21'(pcrps_pkg::CENTER_X) + 21'(fin_qx_q);
	assign py_c = 21'(pcrps_pkg::CENTER_Y) - 21'(fin_qy_q);
	assign vis_c = (px_c >= 21'sd1) && (px_c < 21'(pcrps_pkg::SCREEN_WIDTH - 1))
		&& (py_c >= 21'sd1) && (py_c < 21'(pcrps_pkg::SCREEN_HEIGHT - 1));
	assign idx_full = 32'(py_c) * 32'(pcrps_pkg::SCREEN_WIDTH) + 32'(px_c);

	assign fin_take = fin_valid_q && (!vis_c || !em_busy_q || (em_k_q == 2'd3));
	assign fin_free = !fin_valid_q || fin_take;
	assign em_load = fin_take && vis_c;

	assign em_off = 19'(em_k_q[0]) + (em_k_q[1] ? 19'(pcrps_pkg::SCREEN_WIDTH) : 19'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q   <= 1'b0;
			dv_cnt_q    <= '0;
			fin_valid_q <= 1'b0;
			em_busy_q   <= 1'b0;
			em_k_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			if (load_div) begin
				dv_busy_q <= 1'b1;
				dv_cnt_q  <= '0;
			end else if (fin_now) begin
				dv_busy_q <= 1'b0;
			end else if (dv_busy_q && !dv_last) begin
				dv_cnt_q <= dv_cnt_q + 1'b1;
			end
			if (fin_now) begin
				fin_valid_q <= 1'b1;
			end else if (fin_take) begin
				fin_valid_q <= 1'b0;
			end
			if (em_load) begin
				em_busy_q <= 1'b1;
				em_k_q    <= '0;
			end else if (em_busy_q) begin
				em_k_q <= em_k_q + 1'b1;
				if (em_k_q == 2'd3) begin
					em_busy_q <= 1'b0;
				end
			end
			done_q <= em_busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load_div) begin
			dx_q     <= abs_x;
			dy_q     <= abs_y;
			rx_q     <= '0;
			ry_q     <= '0;
			dz_q     <= head_data.cz;
			sx_q     <= head_data.num_x[DW-1];
			sy_q     <= head_data.num_y[DW-1];
			dv_bgr_q <= head_data.bgr;
		end else if (dv_busy_q && !dv_last) begin
			dx_q <= pass_x[DW-1:0];
			dy_q <= pass_y[DW-1:0];
			rx_q <= pass_x[ZW+DW-1:DW];
			ry_q <= pass_y[ZW+DW-1:DW];
		end
		if (fin_now) begin
			fin_qx_q  <= qx_c;
			fin_qy_q  <= qy_c;
			fin_bgr_q <= dv_bgr_q;
		end
		if (em_load) begin
			em_base_q <= idx_full[18:0];
			em_bgr_q  <= fin_bgr_q;
		end
		idx_q    <= em_base_q + em_off;
		colour_q <= {8'hFF, em_bgr_q};
		last_q   <= (em_k_q == 2'd3);
	end

	assign done         = done_q;
	assign pixel_index  = idx_q;
	assign pixel_colour = colour_q;
	assign splat_last   = last_q;

endmodule
